FILE: hw/rtl/matrix_chain_min_cost_assert.svh
// ----------------------------------------------------------------------------
// Matrix chain cost assertion macros
// Shared helpers for concurrent checks; clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef MATRIX_CHAIN_MIN_COST_ASSERT_SVH
`define MATRIX_CHAIN_MIN_COST_ASSERT_SVH

// same-cycle implication
`define MCM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mcm_pkg.sv
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared constants, result codes and datapath control type.
// ----------------------------------------------------------------------------
package mcm_pkg;

  localparam int unsigned MAX_MATRICES_DEF = 32;
  localparam int unsigned DIM_BITS_DEF     = 12;

  localparam int unsigned COST_W = 48;
  localparam int unsigned ERR_W  = 2;

  // saturation ceiling for every cost sum
  localparam logic [COST_W-1:0] COST_LIMIT = {COST_W{1'b1}};

  // result codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_SHORT = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LONG  = 2'd2;

  // per-cycle controls from the sequencer to the shared datapath
  typedef struct packed {
    logic clear_ovf;
    logic load_di;
    logic load_dj1;
    logic mul_first;
    logic mul_second;
    logic add_pair;
    logic add_prod;
    logic first_split;
    logic zero_left;
    logic zero_right;
  } alu_ctl_t;

endpackage

FILE: hw/rtl/mcm_dim_if.sv
// ----------------------------------------------------------------------------
// mcm_dim_if
// Dimension input channel: valid/ready with one dimension per transfer.
// ----------------------------------------------------------------------------
interface mcm_dim_if #(
  parameter int unsigned DIM_BITS = mcm_pkg::DIM_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] dim_value;
  logic                is_last;

  modport source (output valid, dim_value, is_last, input ready);
  modport sink   (input valid, dim_value, is_last, output ready);
endinterface

FILE: hw/rtl/mcm_cost_if.sv
// ----------------------------------------------------------------------------
// mcm_cost_if
// Result channel: valid/ready carrying the chain cost, flag and error code.
// ----------------------------------------------------------------------------
interface mcm_cost_if ();
  logic                        valid;
  logic                        ready;
  logic [mcm_pkg::COST_W-1:0]  min_cost;
  logic                        saturated;
  logic [mcm_pkg::ERR_W-1:0]   error_code;

  modport source (output valid, min_cost, saturated, error_code, input ready);
  modport sink   (input valid, min_cost, saturated, error_code, output ready);
endinterface

FILE: hw/rtl/matrix_chain_min_cost.sv
// ----------------------------------------------------------------------------
// Matrix chain minimum cost: loads one dimension per cycle while idle with the
// result slot free; after the last one, the interval program runs on a shared
// multiply/add unit, with states K0..K3 per split point and CELL_A, CELL_B and
// WRITE per cell. Errors and single matrices answer next cycle. Synchronous rst
// clears sequencer, count, flag and result valid.
// ----------------------------------------------------------------------------
`include "matrix_chain_min_cost_assert.svh"

module matrix_chain_min_cost #(
  parameter int unsigned MAX_MATRICES = mcm_pkg::MAX_MATRICES_DEF,
  parameter int unsigned DIM_BITS     = mcm_pkg::DIM_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  mcm_dim_if.sink           dims,
  mcm_cost_if.source        cost
);

  localparam int unsigned STORE_DEPTH = MAX_MATRICES + 1;
  localparam int unsigned COUNT_STUCK = MAX_MATRICES + 2;
  localparam int unsigned IW  = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int unsigned DAW = $clog2(STORE_DEPTH);
  localparam int unsigned CNW = $clog2(COUNT_STUCK + 1);
  localparam int unsigned LW  = $clog2(MAX_MATRICES + 1);
  localparam int unsigned TAW = 2 * IW;
  localparam int unsigned CW  = mcm_pkg::COST_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CELL_A = 3'd1;
  localparam logic [2:0] S_CELL_B = 3'd2;
  localparam logic [2:0] S_K0     = 3'd3;
  localparam logic [2:0] S_K1     = 3'd4;
  localparam logic [2:0] S_K2     = 3'd5;
  localparam logic [2:0] S_K3     = 3'd6;
  localparam logic [2:0] S_WRITE  = 3'd7;

  logic [2:0]     state;
  logic [CNW-1:0] cnt;
  logic [CNW-1:0] cnt_next;
  logic [LW-1:0]  nmat;
  logic [LW-1:0]  len;
  logic [IW-1:0]  i;
  logic [IW-1:0]  j;
  logic [IW-1:0]  k;

  logic                          out_valid;
  logic [CW-1:0]                 out_cost;
  logic                          out_sat;
  logic [mcm_pkg::ERR_W-1:0]     out_err;

  logic                 in_xfer;
  logic                 dim_we;
  logic [DAW-1:0]       dim_raddr;
  logic [DIM_BITS-1:0]  dim_rd;
  logic [TAW-1:0]       cost_raddr_a;
  logic [TAW-1:0]       cost_raddr_b;
  logic [CW-1:0]        cost_rd_a;
  logic [CW-1:0]        cost_rd_b;
  logic                 cost_we;
  logic [CW-1:0]        best;
  logic                 ovf;
  logic                 k_first;
  logic                 k_last;
  mcm_pkg::alu_ctl_t    ctl;

  // input handshake: only between chains, and only with the result slot free
  assign dims.ready = (state == S_IDLE) && (!out_valid || cost.ready);
  assign in_xfer    = dims.valid && dims.ready;

  assign cost.valid      = out_valid;
  assign cost.min_cost   = out_cost;
  assign cost.saturated  = out_sat;
  assign cost.error_code = out_err;

  // item count saturates one past capacity
  assign cnt_next = (cnt < CNW'(COUNT_STUCK)) ? CNW'(cnt + 1'b1) : cnt;
  assign dim_we   = in_xfer && (cnt < CNW'(STORE_DEPTH));

  assign k_first = (k == i);
  assign k_last  = (IW'(k + 1'b1) == j);

  mcm_dim_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (DIM_BITS),
    .AW    (DAW)
  ) u_dim_ram (
    .clk   (clk),
    .we    (dim_we),
    .waddr (cnt[DAW-1:0]),
    .wdata (DIM_BITS'(dims.dim_value)),
    .raddr (dim_raddr),
    .rdata (dim_rd)
  );

  mcm_cost_ram #(
    .AW    (TAW),
    .WIDTH (CW)
  ) u_cost_ram (
    .clk     (clk),
    .we      (cost_we),
    .waddr   ({i, j}),
    .wdata   (best),
    .raddr_a (cost_raddr_a),
    .raddr_b (cost_raddr_b),
    .rdata_a (cost_rd_a),
    .rdata_b (cost_rd_b)
  );

  mcm_alu #(
    .DIM_BITS (DIM_BITS)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .dim_rd (dim_rd),
    .left   (cost_rd_a),
    .right  (cost_rd_b),
    .best   (best),
    .ovf    (ovf)
  );

  // memory addresses and datapath controls per state
  always_comb begin
    ctl           = '0;
    ctl.clear_ovf = in_xfer && dims.is_last;
    dim_raddr     = DAW'(i);
    cost_raddr_a  = {i, k};
    cost_raddr_b  = {IW'(k + 1'b1), j};
    cost_we       = 1'b0;
    unique case (state)
      S_IDLE: begin
      end
      S_CELL_A: begin
        dim_raddr = DAW'(i);
      end
      S_CELL_B: begin
        dim_raddr   = DAW'(32'(j) + 32'd1);
        ctl.load_di = 1'b1;
      end
      S_K0: begin
        dim_raddr    = DAW'(32'(k) + 32'd1);
        ctl.load_dj1 = k_first;
      end
      S_K1: begin
        ctl.mul_first  = 1'b1;
        ctl.add_pair   = 1'b1;
        // diagonal cells cost nothing and are never stored
        ctl.zero_left  = k_first;
        ctl.zero_right = k_last;
      end
      S_K2: begin
        ctl.mul_second = 1'b1;
      end
      S_K3: begin
        ctl.add_prod    = 1'b1;
        ctl.first_split = k_first;
      end
      S_WRITE: begin
        cost_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cost.valid && cost.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (!dims.is_last) begin
              cnt <= cnt_next;
            end else begin
              cnt <= '0;
              if (cnt_next < CNW'(2)) begin
                out_valid <= 1'b1;
                out_cost  <= '0;
                out_sat   <= 1'b0;
                out_err   <= mcm_pkg::ERR_SHORT;
              end else if (cnt_next > CNW'(STORE_DEPTH)) begin
                out_valid <= 1'b1;
                out_cost  <= '0;
                out_sat   <= 1'b0;
                out_err   <= mcm_pkg::ERR_LONG;
              end else if (cnt_next == CNW'(2)) begin
                // single matrix
                out_valid <= 1'b1;
                out_cost  <= '0;
                out_sat   <= 1'b0;
                out_err   <= mcm_pkg::ERR_OK;
              end else begin
                nmat  <= LW'(cnt_next - 1'b1);
                len   <= LW'(2);
                i     <= '0;
                state <= S_CELL_A;
              end
            end
          end
        end
        S_CELL_A: begin
          j     <= IW'(32'(i) + 32'(len) - 32'd1);
          k     <= i;
          state <= S_CELL_B;
        end
        S_CELL_B: begin
          state <= S_K0;
        end
        S_K0: begin
          state <= S_K1;
        end
        S_K1: begin
          state <= S_K2;
        end
        S_K2: begin
          state <= S_K3;
        end
        S_K3: begin
          if (k_last) begin
            state <= S_WRITE;
          end else begin
            k     <= IW'(k + 1'b1);
            state <= S_K0;
          end
        end
        S_WRITE: begin
          if (32'(i) + 32'(len) < 32'(nmat)) begin
            i     <= IW'(i + 1'b1);
            state <= S_CELL_A;
          end else if (len < nmat) begin
            len   <= LW'(len + 1'b1);
            i     <= '0;
            state <= S_CELL_A;
          end else begin
            // whole-chain cell just finished
            out_valid <= 1'b1;
            out_cost  <= best;
            out_sat   <= ovf;
            out_err   <= mcm_pkg::ERR_OK;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `MCM_ASSERT_IMP(a_err_clean, cost.valid && cost.error_code != mcm_pkg::ERR_OK, cost.min_cost == '0 && !cost.saturated, "error result carries cost or flag")
  `MCM_ASSERT_IMP(a_split_range, state == S_K3, k < j, "split point ran past interval end")
  `MCM_ASSERT_NXT(a_write_next, state == S_WRITE, state == S_CELL_A || state == S_IDLE, "bad state after cell write")
  `MCM_ASSERT_IMP(a_result_src, $rose(cost.valid), $past(state == S_WRITE || (dims.valid && dims.ready && dims.is_last)), "result without closing item or finished chain")

endmodule

FILE: hw/rtl/mcm_dim_ram.sv
// ----------------------------------------------------------------------------
// mcm_dim_ram
// Dimension store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mcm_dim_ram #(
  parameter int unsigned DEPTH = mcm_pkg::MAX_MATRICES_DEF + 1,
  parameter int unsigned WIDTH = mcm_pkg::DIM_BITS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/mcm_cost_ram.sv
// ----------------------------------------------------------------------------
// mcm_cost_ram
// Interval cost table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mcm_cost_ram #(
  parameter int unsigned AW    = 10,
  parameter int unsigned WIDTH = mcm_pkg::COST_W
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hw/rtl/mcm_alu.sv
// ----------------------------------------------------------------------------
// mcm_alu
// Shared datapath: one multiplier and one saturating adder/compare, reused
// for every split point under sequencer control.
// ----------------------------------------------------------------------------
module mcm_alu #(
  parameter int unsigned DIM_BITS = mcm_pkg::DIM_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mcm_pkg::alu_ctl_t          ctl,
  input  logic [DIM_BITS-1:0]        dim_rd,
  input  logic [mcm_pkg::COST_W-1:0] left,
  input  logic [mcm_pkg::COST_W-1:0] right,
  output logic [mcm_pkg::COST_W-1:0] best,
  output logic                       ovf
);

  localparam int unsigned PW = 2 * DIM_BITS;
  localparam int unsigned MW = 3 * DIM_BITS;
  localparam int unsigned CW = mcm_pkg::COST_W;

  logic [DIM_BITS-1:0] di;
  logic [DIM_BITS-1:0] dj1;
  logic [PW-1:0]       p1;
  logic [CW-1:0]       prod;
  logic [CW-1:0]       s;

  logic [PW-1:0]       mul_a;
  logic [DIM_BITS-1:0] mul_b;
  logic [MW-1:0]       mul_y;
  logic [CW-1:0]       add_a;
  logic [CW-1:0]       add_b;
  logic [CW:0]         add_y;
  logic                add_sat;
  logic [CW-1:0]       add_q;

  // multiplier: d[i]*d[k+1] first, then that product times d[j+1]
  assign mul_a = ctl.mul_second ? p1 : PW'(di);
  assign mul_b = ctl.mul_second ? dj1 : dim_rd;
  assign mul_y = MW'(mul_a) * MW'(mul_b);

  // adder: left+right first, then partial sum plus the product
  always_comb begin
    if (ctl.add_prod) begin
      add_a = s;
      add_b = prod;
    end else begin
      add_a = ctl.zero_left  ? '0 : left;
      add_b = ctl.zero_right ? '0 : right;
    end
  end

  assign add_y   = {1'b0, add_a} + {1'b0, add_b};
  assign add_sat = add_y >= {1'b0, mcm_pkg::COST_LIMIT};
  assign add_q   = add_sat ? mcm_pkg::COST_LIMIT : add_y[CW-1:0];

  // operand and result registers
  always_ff @(posedge clk) begin
    if (ctl.load_di) begin
      di <= dim_rd;
    end
    if (ctl.load_dj1) begin
      dj1 <= dim_rd;
    end
    if (ctl.mul_first) begin
      p1 <= mul_y[PW-1:0];
    end
    if (ctl.mul_second) begin
      prod <= CW'(mul_y);
    end
    if (ctl.add_pair) begin
      s <= add_q;
    end
    // earliest split wins a tie
    if (ctl.add_prod && (ctl.first_split || add_q < best)) begin
      best <= add_q;
    end
  end

  // saturation seen anywhere in the current chain
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else if (ctl.clear_ovf) begin
      ovf <= 1'b0;
    end else if ((ctl.add_pair || ctl.add_prod) && add_sat) begin
      ovf <= 1'b1;
    end
  end

endmodule
